@@ design/crd_pkg.sv @@
package crd_pkg;

	typedef enum logic [2:0] {
		PH_HEAD0     = 3'd0,
		PH_HEAD1     = 3'd1,
		PH_HEAD1_CLR = 3'd2,
		PH_ID_LO     = 3'd3,
		PH_ID_HI     = 3'd4,
		PH_SIZE      = 3'd5,
		PH_VALUE     = 3'd6,
		PH_TAIL      = 3'd7
	} phase_t;

	localparam int FLAG_W = 33;
	localparam int LIMIT_W = 48;
	localparam int VBUF_D = 7;

	localparam logic [15:0] ID_FAN      = 16'h0210;
	localparam logic [15:0] ID_ECO      = 16'h0212;
	localparam logic [15:0] ID_FREEZE   = 16'h0213;
	localparam logic [15:0] ID_MODES    = 16'h0214;
	localparam logic [15:0] ID_SWING    = 16'h0215;
	localparam logic [15:0] ID_TURBO    = 16'h021A;
	localparam logic [15:0] ID_ANION    = 16'h021E;
	localparam logic [15:0] ID_HUMIDITY = 16'h021F;
	localparam logic [15:0] ID_UNIT     = 16'h0222;
	localparam logic [15:0] ID_DISPLAY  = 16'h0224;
	localparam logic [15:0] ID_TEMPS    = 16'h0225;
	localparam logic [15:0] ID_IECO     = 16'h00E3;
	localparam logic [15:0] ID_SILENT   = 16'h00CD;
	localparam logic [15:0] ID_CLEAN    = 16'h0039;
	localparam logic [15:0] ID_BREEZE   = 16'h0042;
	localparam logic [15:0] ID_BRZLESS  = 16'h0018;
	localparam logic [15:0] ID_FLASH    = 16'h0067;
	localparam logic [15:0] ID_RATE     = 16'h0048;
	localparam logic [15:0] ID_CASCADE  = 16'h0059;
	localparam logic [15:0] ID_FRESH    = 16'h004B;

	typedef struct packed {
		logic [FLAG_W-1:0]  present;
		logic [FLAG_W-1:0]  value;
		logic [3:0]         ieco;
		logic               temps_known;
		logic [LIMIT_W-1:0] limits;
		logic               decimals;
	} cap_map_t;

	function automatic logic in_set(input logic [7:0] v, input logic [15:0] mask);
		return (v[7:4] == 4'd0) && mask[v[3:0]];
	endfunction

endpackage

@@ design/crd_merge.sv @@
module crd_merge import crd_pkg::*; (
	input  logic [15:0]          ident,
	input  logic [7:0]           length,
	input  logic [VBUF_D*8-1:0]  vbuf,
	input  cap_map_t             map_in,
	output cap_map_t             map_out
);

	logic [FLAG_W-1:0] put_m;
	logic [FLAG_W-1:0] put_v;
	logic [7:0]        v;
	logic [7:0]        e;

	assign v = vbuf[7:0];
	assign e = (length >= 8'd2) ? vbuf[15:8] : 8'd0;

	always_comb begin
		put_m = '0;
		put_v = '0;
		map_out = map_in;
		unique case (ident)
			ID_ANION: begin put_m[0] = 1'b1; put_v[0] = (v == 8'd1); end
			ID_ECO: begin put_m[1] = 1'b1; put_v[1] = in_set(v, 16'h0006); end
			ID_FREEZE: begin put_m[2] = 1'b1; put_v[2] = (v == 8'd1); end
			ID_UNIT: begin put_m[3] = 1'b1; put_v[3] = (v == 8'd0); end
			ID_MODES: begin
				put_m[9:4] = 6'h3F;
				put_v[4] = in_set(v, 16'h3ED6);
				put_v[5] = in_set(v, 16'hEBFB);
				put_v[6] = in_set(v, 16'hEA63);
				put_v[7] = in_set(v, 16'h6387);
				put_v[8] = (v == 8'd9);
				put_v[9] = in_set(v, 16'hEE00);
			end
			ID_SWING: begin
				put_m[11:10] = 2'b11;
				put_v[10] = in_set(v, 16'h000A);
				put_v[11] = in_set(v, 16'h0003);
			end
			ID_FAN: begin
				put_m[17:12] = 6'h3F;
				put_v[12] = in_set(v, 16'h0240);
				put_v[13] = in_set(v, 16'h02F8);
				put_v[14] = in_set(v, 16'h00E0);
				put_v[15] = in_set(v, 16'h02F8);
				put_v[16] = in_set(v, 16'h0270);
				put_v[17] = (v == 8'd1);
			end
			ID_HUMIDITY: begin
				put_m[19:18] = 2'b11;
				put_v[18] = in_set(v, 16'h0006);
				put_v[19] = in_set(v, 16'h000C);
			end
			ID_TURBO: begin
				put_m[21:20] = 2'b11;
				put_v[20] = in_set(v, 16'h000A);
				put_v[21] = in_set(v, 16'h0003);
			end
			ID_IECO: begin
				put_m[22] = 1'b1;
				put_v[22] = in_set(v, 16'h011A) || in_set(e, 16'h010E);
				map_out.ieco = (e == 8'd8) ? 4'd8 : (in_set(e, 16'h000E) ? 4'd3 : 4'd1);
			end
			ID_SILENT: begin put_m[23] = 1'b1; put_v[23] = in_set(v, 16'h000A); end
			ID_CLEAN: begin put_m[24] = 1'b1; put_v[24] = (v == 8'd1); end
			ID_BREEZE: begin put_m[25] = 1'b1; put_v[25] = (v == 8'd1); end
			ID_BRZLESS: begin put_m[26] = 1'b1; put_v[26] = (v == 8'd1); end
			ID_FLASH: begin put_m[27] = 1'b1; put_v[27] = in_set(v, 16'h001E); end
			ID_RATE: begin
				put_m[29:28] = 2'b11;
				put_v[28] = (v == 8'd1);
				put_v[29] = in_set(v, 16'h000C);
			end
			ID_CASCADE: begin put_m[30] = 1'b1; put_v[30] = (v == 8'd1); end
			ID_FRESH: begin put_m[31] = 1'b1; put_v[31] = (v == 8'd1); end
			ID_DISPLAY: begin
				put_m[32] = 1'b1;
				put_v[32] = (v == 8'd1) || (v == 8'd2) || (v == 8'd100);
			end
			ID_TEMPS: begin
				map_out.temps_known = 1'b1;
				map_out.limits = vbuf[LIMIT_W-1:0];
				map_out.decimals = (length > 8'd6) ? (vbuf[55:48] != 8'd0) : 1'b1;
			end
			default: begin
			end
		endcase
		map_out.present = map_in.present | put_m;
		map_out.value = (map_in.value & ~put_m) | (put_v & put_m);
	end

endmodule

@@ design/capability_record_decoder.sv @@
// Channel | Direction | Signals
// in      | sink      | in_valid, in_stall, payload_byte, last_byte, restart_map
// out     | source    | out_valid, out_stall, payload_ok .. more_pending
// Each byte passes through the input register; one byte can be accepted in every cycle unless the input is stalled.
// The input register feeds the parse step and the record merge, whose result
// lands in the output register when the byte marked last advances out of the input register.
// Reset clears the parse state and sets the map to its defaults.
// The input stalls only while a finished word waits in the output register
// and the output is itself stalled.
module capability_record_decoder import crd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          payload_byte,
	input  logic                last_byte,
	input  logic                restart_map,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                payload_ok,
	output logic [FLAG_W-1:0]   present_bits,
	output logic [FLAG_W-1:0]   value_bits,
	output logic [3:0]          ieco_levels,
	output logic                temps_known,
	output logic [LIMIT_W-1:0]  temp_limits,
	output logic                temp_decimals,
	output logic                more_pending
);

	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 rst_s1;
	phase_t               phase_q;
	logic [7:0]           left_q;
	logic [15:0]          ident_q;
	logic [7:0]           len_q;
	logic [7:0]           vleft_q;
	logic [VBUF_D*8-1:0]  vbuf_q;
	logic [1:0]           tail_q;
	logic [7:0]           prev_q;
	cap_map_t             map_q;
	cap_map_t             map_clr;
	cap_map_t             map_dec;
	cap_map_t             map_nx;
	logic [VBUF_D*8-1:0]  vbuf_nx;
	logic [7:0]           idx;
	logic [7:0]           vleft_dec;
	logic                 ok;
	logic                 adv;
	logic                 fire;
	logic                 tail_nx_ge2;
	phase_t               phase_nx;

	assign adv = vld_s1 && !(last_s1 && out_valid && out_stall);
	assign in_stall = vld_s1 && !adv;
	assign fire = adv && last_s1;

	assign map_clr = '{present: '0, value: '0, ieco: 4'd1, temps_known: 1'b0,
		limits: '0, decimals: 1'b0};

	assign idx = len_q - vleft_q;
	assign vleft_dec = vleft_q - 8'd1;

	always_comb begin
		vbuf_nx = vbuf_q;
		for (int i = 0; i < VBUF_D; i++) begin
			if (idx == 8'(i)) vbuf_nx[i*8 +: 8] = byte_s1;
		end
	end

	crd_merge u_merge (
		.ident   (ident_q),
		.length  (len_q),
		.vbuf    (vbuf_nx),
		.map_in  (map_q),
		.map_out (map_dec)
	);

	always_comb begin
		phase_nx = phase_q;
		map_nx = map_q;
		ok = 1'b1;
		unique case (phase_q)
			PH_HEAD0: begin
				ok = 1'b0;
				phase_nx = rst_s1 ? PH_HEAD1_CLR : PH_HEAD1;
			end
			PH_HEAD1, PH_HEAD1_CLR: begin
				if (phase_q == PH_HEAD1_CLR) map_nx = map_clr;
				phase_nx = (byte_s1 == 8'd0) ? PH_TAIL : PH_ID_LO;
			end
			PH_ID_LO: phase_nx = PH_ID_HI;
			PH_ID_HI: phase_nx = PH_SIZE;
			PH_SIZE: begin
				if (byte_s1 == 8'd0)
					phase_nx = (left_q == 8'd1) ? PH_TAIL : PH_ID_LO;
				else
					phase_nx = PH_VALUE;
			end
			PH_VALUE: begin
				if (vleft_dec == 8'd0) begin
					if (ident_q == ID_TEMPS && len_q < 8'd6) begin
						phase_nx = PH_TAIL;
					end else begin
						map_nx = map_dec;
						phase_nx = (left_q == 8'd1) ? PH_TAIL : PH_ID_LO;
					end
				end
			end
			PH_TAIL: phase_nx = PH_TAIL;
			default: phase_nx = PH_HEAD0;
		endcase
	end

	// Whether the tail count as seen at the end of this byte has reached two, where it saturates.
	always_comb begin
		tail_nx_ge2 = 1'b0;
		if (phase_q >= PH_ID_LO && tail_q != 2'd0) tail_nx_ge2 = 1'b1;
		if (phase_nx != PH_TAIL || phase_q != PH_TAIL) begin
			if (phase_q < PH_ID_LO) tail_nx_ge2 = 1'b0;
			else if (phase_nx != phase_q && phase_nx == PH_TAIL
				&& !(phase_q == PH_VALUE && ident_q == ID_TEMPS && len_q < 8'd6))
				tail_nx_ge2 = 1'b0;
			else if (phase_nx == PH_ID_LO) tail_nx_ge2 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= payload_byte;
			last_s1 <= last_byte;
			rst_s1 <= restart_map;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD0;
			left_q <= '0;
			ident_q <= '0;
			len_q <= '0;
			vleft_q <= '0;
			vbuf_q <= '0;
			tail_q <= '0;
			prev_q <= '0;
			map_q <= map_clr;
			out_valid <= 1'b0;
			payload_ok <= 1'b0;
			present_bits <= '0;
			value_bits <= '0;
			ieco_levels <= 4'd1;
			temps_known <= 1'b0;
			temp_limits <= '0;
			temp_decimals <= 1'b0;
			more_pending <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !fire) out_valid <= 1'b0;
			if (adv) begin
				prev_q <= byte_s1;
				map_q <= map_nx;
				unique case (phase_q)
					PH_HEAD1, PH_HEAD1_CLR: left_q <= byte_s1;
					PH_ID_LO: ident_q <= {8'd0, byte_s1};
					PH_ID_HI: ident_q <= {byte_s1, ident_q[7:0]};
					PH_SIZE: begin
						len_q <= byte_s1;
						vleft_q <= byte_s1;
						if (byte_s1 == 8'd0) left_q <= left_q - 8'd1;
					end
					PH_VALUE: begin
						vbuf_q <= vbuf_nx;
						vleft_q <= vleft_dec;
						if (vleft_dec == 8'd0 && !(ident_q == ID_TEMPS && len_q < 8'd6))
							left_q <= left_q - 8'd1;
					end
					default: begin
					end
				endcase
				if (phase_q < PH_ID_LO || (phase_nx != phase_q
					&& (phase_nx == PH_ID_LO || (phase_nx == PH_TAIL
					&& !(phase_q == PH_VALUE && ident_q == ID_TEMPS && len_q < 8'd6)))))
					tail_q <= 2'd0;
				else if (tail_q != 2'd2)
					tail_q <= tail_q + 2'd1;
				if (last_s1) begin
					phase_q <= PH_HEAD0;
					left_q <= '0;
					vleft_q <= '0;
					tail_q <= '0;
					out_valid <= 1'b1;
					payload_ok <= ok;
					present_bits <= map_nx.present;
					value_bits <= map_nx.value & map_nx.present;
					ieco_levels <= map_nx.ieco;
					temps_known <= map_nx.temps_known;
					temp_limits <= map_nx.limits;
					temp_decimals <= map_nx.decimals;
					more_pending <= ok && phase_nx >= PH_ID_LO && tail_nx_ge2
						&& prev_q != 8'd0;
				end else begin
					phase_q <= phase_nx;
				end
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(present_bits))
		else $error("result word changed while stalled");
	a_ieco: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ieco_levels == 4'd1 || ieco_levels == 4'd3 || ieco_levels == 4'd8)
		else $error("bad ieco level count");
	a_vals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value_bits & ~present_bits) == '0)
		else $error("value bit without present bit");
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_ok |-> !more_pending)
		else $error("more pending on a short payload");

endmodule
